>>> rtl/core/ffsa_pkg.sv
package ffsa_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_REALLOC = 2'd1,
		OP_FREE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_UNCHANGED = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Table edit broadcast to every cell: drop one entry, insert one entry.
	typedef struct packed {
		logic       rm_en;
		logic [5:0] rm_idx;
		logic       ins_en;
		logic [7:0] ins_start;
		logic [7:0] ins_len;
	} edit_t;

endpackage

>>> rtl/core/ffsa_cell.sv
module ffsa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  ffsa_pkg::edit_t     edit,
	input  logic [5:0]          my_idx,
	// Neighbor on the low side and on the high side.
	input  logic                lo_valid,
	input  logic [7:0]          lo_start,
	input  logic [7:0]          lo_len,
	input  logic                hi_valid,
	input  logic [7:0]          hi_start,
	input  logic [7:0]          hi_len,
	output logic                valid,
	output logic [7:0]          start,
	output logic [7:0]          len
);
	import ffsa_pkg::*;

	logic       valid_q;
	logic [7:0] start_q;
	logic [7:0] len_q;
	logic       src_valid;
	logic [7:0] src_start;
	logic [7:0] src_len;
	logic       lo_c_valid;
	logic       lo_before;
	logic       src_after;
	logic [5:0] src_idx;

	assign valid = valid_q;
	assign start = start_q;
	assign len   = len_q;

	// After removal this slot holds the next entry up when at or above the hole.
	always_comb begin
		if (edit.rm_en && my_idx >= edit.rm_idx) begin
			src_valid = hi_valid;
			src_start = hi_start;
			src_len   = hi_len;
		end else begin
			src_valid = valid_q;
			src_start = start_q;
			src_len   = len_q;
		end
	end

	// Compacted view of the low neighbor.
	always_comb begin
		src_idx = my_idx;
		if (edit.rm_en && my_idx - 6'd1 >= edit.rm_idx) begin
			lo_c_valid = valid_q;
			lo_before = (my_idx == 6'd0) ? 1'b1 : valid_q && start_q < edit.ins_start;
		end else begin
			lo_c_valid = lo_valid;
			lo_before = (my_idx == 6'd0) ? 1'b1 : lo_valid && lo_start < edit.ins_start;
		end
		src_after = !(src_valid && src_start < edit.ins_start);
	end

	// Above the insertion point a slot takes over the validity of the entry below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			if (!edit.ins_en) begin
				valid_q <= src_valid;
			end else if (src_after && !lo_before) begin
				valid_q <= lo_c_valid;
			end else begin
				valid_q <= src_valid || (src_after && lo_before);
			end
		end
	end

	// Insert: shift up if the compacted entry here lies past the new start.
	always_ff @(posedge clk) begin
		if (upd) begin
			if (!edit.ins_en || !src_after) begin
				start_q <= src_start;
				len_q   <= src_len;
			end else if (lo_before) begin
				start_q <= edit.ins_start;
				len_q   <= edit.ins_len;
			end else if (edit.rm_en && src_idx - 6'd1 >= edit.rm_idx) begin
				start_q <= start_q;
				len_q   <= len_q;
			end else begin
				start_q <= lo_start;
				len_q   <= lo_len;
			end
		end
	end
endmodule

>>> rtl/core/first_fit_segment_allocator.sv
// First-fit segment allocator.
// The input channel (in_valid/in_stall) carries op, req_size and handle. The
// output channel (out_valid/out_stall) carries status, seg_offset, free_left.
// The live segments sit in a row of cells, one entry each, kept in address
// order and packed at the low end. After the input transaction is accepted,
// the sequencer passes through a scan state (lookup, tail end, first gap)
// that decides and registers status and offset, an edit state that applies
// the table edit in every cell at once, and an output state that raises
// out_valid. One request is in flight at a time; the next is taken in the
// cycle after the result transaction completes. While the receiver stalls,
// the result holds and the input stalls. Reset empties the table and sets
// the free count to USABLE_BYTES; no clearing pass is needed.
module first_fit_segment_allocator #(
	parameter int USABLE_BYTES = 255,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] req_size,
	input  logic [7:0] handle,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] seg_offset,
	output logic [7:0] free_left
);
	import ffsa_pkg::*;

	localparam int FW = $clog2(USABLE_BYTES + 1) + 1;
	localparam logic [FW-1:0] USABLE = FW'(USABLE_BYTES);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EDIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [1:0]    op_q;
	logic [7:0]    size_q;
	logic [7:0]    handle_q;
	logic [FW-1:0] free_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [7:0]    offset_q;
	logic          upd;
	edit_t         edit_q;

	logic       cv [MAX_SEGMENTS];
	logic [7:0] cs [MAX_SEGMENTS];
	logic [7:0] cl [MAX_SEGMENTS];

	// Row of cells holding the ordered table.
	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		logic       lv, hv;
		logic [7:0] ls, ll, hs, hl;
		if (g == 0) begin : g_lo0
			assign lv = 1'b0;
			assign ls = '0;
			assign ll = '0;
		end else begin : g_lo
			assign lv = cv[g-1];
			assign ls = cs[g-1];
			assign ll = cl[g-1];
		end
		if (g == MAX_SEGMENTS - 1) begin : g_hiN
			assign hv = 1'b0;
			assign hs = '0;
			assign hl = '0;
		end else begin : g_hi
			assign hv = cv[g+1];
			assign hs = cs[g+1];
			assign hl = cl[g+1];
		end
		ffsa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .upd(upd), .edit(edit_q),
			.my_idx(6'(g)),
			.lo_valid(lv), .lo_start(ls), .lo_len(ll),
			.hi_valid(hv), .hi_start(hs), .hi_len(hl),
			.valid(cv[g]), .start(cs[g]), .len(cl[g])
		);
	end

	// Per-cell scan terms: match, tail end, gap before each entry.
	logic          hit [MAX_SEGMENTS];
	logic          fit [MAX_SEGMENTS];
	logic [FW-1:0] endp [MAX_SEGMENTS];
	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_scan
		logic [FW-1:0] prev_end;
		if (g == 0) begin : g_p0
			assign prev_end = '0;
		end else begin : g_p
			assign prev_end = FW'(cs[g-1]) + FW'(cl[g-1]);
		end
		assign endp[g] = FW'(cs[g]) + FW'(cl[g]);
		assign hit[g]  = cv[g] && cs[g] == handle_q;
		assign fit[g]  = cv[g] && FW'(cs[g]) >= prev_end
			&& FW'(cs[g]) - prev_end >= FW'(size_q);
	end

	// Priority picks over the row.
	logic          found, full, gap_ok;
	logic [5:0]    hit_idx;
	logic [7:0]    hit_len;
	logic [FW-1:0] last_end, gap_at;
	always_comb begin
		found    = 1'b0;
		hit_idx  = '0;
		hit_len  = '0;
		last_end = '0;
		gap_ok   = 1'b0;
		gap_at   = '0;
		full     = cv[MAX_SEGMENTS-1];
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found   = 1'b1;
				hit_idx = 6'(i);
				hit_len = cl[i];
			end
			if (fit[i]) begin
				gap_ok = 1'b1;
				gap_at = (i == 0) ? '0 : endp[(i == 0) ? 0 : i - 1];
			end
		end
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (cv[i]) last_end = endp[i];
		end
	end

	logic bad_size;
	logic tail_ok;
	assign bad_size = size_q == 8'd0 || FW'(size_q) > free_q;
	assign tail_ok  = last_end <= USABLE && USABLE - last_end >= FW'(size_q);

	assign upd       = state_q == S_EDIT;
	assign in_stall  = state_q != S_IDLE || out_valid_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign seg_offset = offset_q;
	assign free_left = free_q[7:0];

	// Sequencer: capture, scan and decide, edit, deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			free_q      <= USABLE;
			edit_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) state_q <= S_SCAN;
				end
				S_SCAN: begin
					edit_q   <= '0;
					status_q <= ST_UNCHANGED;
					offset_q <= '0;
					case (op_q)
						OP_ALLOC: begin
							if (bad_size) begin
								status_q <= ST_UNCHANGED;
							end else if (full || !tail_ok) begin
								status_q <= ST_NO_SPACE;
							end else begin
								status_q         <= ST_OK;
								offset_q         <= last_end[7:0];
								edit_q.ins_en    <= 1'b1;
								edit_q.ins_start <= last_end[7:0];
								edit_q.ins_len   <= size_q;
								free_q           <= free_q - FW'(size_q);
							end
						end
						OP_REALLOC: begin
							if (bad_size) begin
								offset_q <= handle_q;
							end else if (!found) begin
								status_q <= ST_NOT_FOUND;
							end else if (!gap_ok && !tail_ok) begin
								status_q <= ST_NO_SPACE;
							end else begin
								status_q         <= ST_OK;
								offset_q         <= gap_ok ? gap_at[7:0] : last_end[7:0];
								edit_q.rm_en     <= 1'b1;
								edit_q.rm_idx    <= hit_idx;
								edit_q.ins_en    <= 1'b1;
								edit_q.ins_start <= gap_ok ? gap_at[7:0] : last_end[7:0];
								edit_q.ins_len   <= size_q;
								free_q           <= free_q + FW'(hit_len) - FW'(size_q);
							end
						end
						OP_FREE: begin
							if (!found) begin
								status_q <= ST_NOT_FOUND;
							end else begin
								status_q      <= ST_OK;
								edit_q.rm_en  <= 1'b1;
								edit_q.rm_idx <= hit_idx;
								free_q        <= free_q + FW'(hit_len);
							end
						end
						default: status_q <= ST_UNCHANGED;
					endcase
					state_q <= S_EDIT;
				end
				S_EDIT: state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q     <= op;
			size_q   <= req_size;
			handle_q <= handle;
		end
	end

	// Checks on the sequencer and the table.
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("stray result");
	a_free_cap: assert property (@(posedge clk) disable iff (!arst_n) free_q <= USABLE)
		else $error("free count above capacity");
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cv[MAX_SEGMENTS-1] |-> cv[0]) else $error("table not packed");
endmodule
